/* rtl/bebp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the back-edge branch predictor.
// Used by the request interface, the controller, the datapath and the top level.
package bebp_pkg;

   localparam int MAX_BLOCKS_DEF = 256;
   localparam int MAX_SUCC_DEF   = 4;

   localparam int ACTION_W = 2;
   localparam int BLOCK_W  = 8;
   localparam int TARGET_W = 8;
   localparam int COUNT_W  = 9;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_QUERY = 2'd3
   } bebp_action_type;

   localparam logic [1:0] COLOR_WHITE = 2'd0;
   localparam logic [1:0] COLOR_GRAY  = 2'd1;
   localparam logic [1:0] COLOR_BLACK = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic sweep_wr;
      logic sweep_cnt;
      logic res_reject;
      logic rd_cnt_req;
      logic add_wr;
      logic walk_init;
      logic rd_root;
      logic root_skip;
      logic root_push;
      logic rd_succ;
      logic rd_tgt;
      logic tgt_push;
      logic tgt_mark;
      logic pop_top;
      logic stack_load;
      logic q_init;
      logic q_rd;
      logic q_cmp;
      logic q_finish;
      logic rsp_load;
   } bebp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic range_bad;
      logic count_bad;
      logic cnt_full;
      logic sweep_last;
      logic root_done;
      logic nd_white;
      logic nd_gray;
      logic top_has_slot;
      logic depth_one;
      logic q_more;
   } bebp_stat_type;

endpackage

/* rtl/bebp_req_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces of the predictor.
// The request interface depends on bebp_pkg for the field widths.
interface bebp_req_if;
   import bebp_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BLOCK_W-1:0]  block;
   logic [TARGET_W-1:0] target;
   logic [COUNT_W-1:0]  block_count;
   modport source (output valid, action, block, target, block_count, input ready);
   modport sink   (input valid, action, block, target, block_count, output ready);
endinterface

interface bebp_rsp_if;
   logic valid;
   logic ready;
   logic predicted;
   logic status;
   modport source (output valid, predicted, status, input ready);
   modport sink   (input valid, predicted, status, output ready);
endinterface

/* rtl/bebp_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the predictor: one-hot state machine issuing datapath commands.
// Depends on bebp_pkg for the command and status structs.
module bebp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  bebp_pkg::bebp_action_type req_action,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bebp_pkg::bebp_stat_type st,
   output bebp_pkg::bebp_cmd_type  cmd
);
   import bebp_pkg::*;

   typedef enum logic [14:0] {
      S_INIT      = 15'b000000000000001,
      S_IDLE      = 15'b000000000000010,
      S_CLEAR     = 15'b000000000000100,
      S_ADD_RD    = 15'b000000000001000,
      S_ADD_WR    = 15'b000000000010000,
      S_RUN       = 15'b000000000100000,
      S_RUN_SWEEP = 15'b000000001000000,
      S_ROOT      = 15'b000000010000000,
      S_ROOT_CHK  = 15'b000000100000000,
      S_EXPAND    = 15'b000001000000000,
      S_SUCC      = 15'b000010000000000,
      S_TGT       = 15'b000100000000000,
      S_POP       = 15'b001000000000000,
      S_Q_RD      = 15'b010000000000000,
      S_DONE      = 15'b100000000000000
   } bebp_state_type;

   // The query loop runs as a small state machine nested inside S_Q_RD.
   typedef enum logic [2:0] {
      QS_OFF  = 3'b001,
      QS_LOOP = 3'b010,
      QS_CMP  = 3'b100
   } bebp_qstate_type;

   bebp_state_type  state_ff, state_in;
   bebp_qstate_type qst_ff, qst_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      qst_in    = qst_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_wr  = 1'b1;
            cmd.sweep_cnt = 1'b1;
            if (st.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_action)
                  ACT_CLEAR: state_in = S_CLEAR;
                  ACT_ADD:   state_in = S_ADD_RD;
                  ACT_RUN:   state_in = S_RUN;
                  default:   state_in = S_Q_RD;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.sweep_wr  = 1'b1;
            cmd.sweep_cnt = 1'b1;
            if (st.sweep_last) state_in = S_DONE;
         end
         S_ADD_RD: begin
            if (st.range_bad) begin
               cmd.res_reject = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_cnt_req = 1'b1;
               state_in = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            if (st.cnt_full) cmd.res_reject = 1'b1;
            else cmd.add_wr = 1'b1;
            state_in = S_DONE;
         end
         S_RUN: begin
            if (st.count_bad) begin
               cmd.res_reject = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.walk_init = 1'b1;
               state_in = S_RUN_SWEEP;
            end
         end
         S_RUN_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (st.sweep_last) state_in = S_ROOT;
         end
         S_ROOT: begin
            if (st.root_done) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_root = 1'b1;
               state_in = S_ROOT_CHK;
            end
         end
         S_ROOT_CHK: begin
            if (st.nd_white) begin
               cmd.root_push = 1'b1;
               state_in = S_EXPAND;
            end else begin
               cmd.root_skip = 1'b1;
               state_in = S_ROOT;
            end
         end
         S_EXPAND: begin
            if (st.top_has_slot) begin
               cmd.rd_succ = 1'b1;
               state_in = S_SUCC;
            end else begin
               cmd.pop_top = 1'b1;
               state_in = st.depth_one ? S_ROOT : S_POP;
            end
         end
         S_SUCC: begin
            cmd.rd_tgt = 1'b1;
            state_in = S_TGT;
         end
         S_TGT: begin
            if (st.nd_white) cmd.tgt_push = 1'b1;
            else if (st.nd_gray) cmd.tgt_mark = 1'b1;
            state_in = S_EXPAND;
         end
         S_POP: begin
            cmd.stack_load = 1'b1;
            state_in = S_EXPAND;
         end
         S_Q_RD: begin
            case (qst_ff)
               QS_OFF: begin
                  if (st.range_bad) begin
                     cmd.res_reject = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     cmd.rd_cnt_req = 1'b1;
                     cmd.q_init = 1'b1;
                     qst_in = QS_LOOP;
                  end
               end
               QS_LOOP: begin
                  if (st.q_more) begin
                     cmd.q_rd = 1'b1;
                     qst_in = QS_CMP;
                  end else begin
                     cmd.q_finish = 1'b1;
                     qst_in = QS_OFF;
                     state_in = S_DONE;
                  end
               end
               QS_CMP: begin
                  cmd.q_cmp = 1'b1;
                  qst_in = QS_LOOP;
               end
               default: qst_in = QS_OFF;
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         qst_ff       <= QS_OFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qst_ff       <= qst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/bebp_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the predictor: successor, count, node and stack memories,
// walk registers and result registers. Depends on bebp_pkg.
module bebp_dpath #(
   parameter int MAX_BLOCKS = bebp_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_SUCC   = bebp_pkg::MAX_SUCC_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bebp_pkg::BLOCK_W-1:0]    req_block,
   input  logic [bebp_pkg::TARGET_W-1:0]   req_target,
   input  logic [bebp_pkg::COUNT_W-1:0]    req_block_count,
   input  bebp_pkg::bebp_cmd_type          cmd,
   output bebp_pkg::bebp_stat_type         st,
   output logic                            rsp_predicted,
   output logic                            rsp_status
);
   import bebp_pkg::*;

   localparam int BW  = $clog2(MAX_BLOCKS);
   localparam int DW  = BW + 1;
   localparam int CW  = $clog2(MAX_SUCC + 1);
   localparam int SLW = (MAX_SUCC > 1) ? $clog2(MAX_SUCC) : 1;
   localparam int AW  = (MAX_BLOCKS * MAX_SUCC > 2) ? $clog2(MAX_BLOCKS * MAX_SUCC) : 1;
   localparam int NW  = 2 + MAX_SUCC;
   localparam int STW = BW + CW + CW + MAX_SUCC;

   // Memories. A node record holds the color and one back-edge mark per slot.
   logic [TARGET_W-1:0] succ_mem  [MAX_BLOCKS*MAX_SUCC];
   logic [CW-1:0]       cnt_mem   [MAX_BLOCKS];
   logic [NW-1:0]       node_mem  [MAX_BLOCKS];
   logic [STW-1:0]      stack_mem [MAX_BLOCKS];

   logic [TARGET_W-1:0] succ_q;
   logic [CW-1:0]       cnt_q;
   logic [NW-1:0]       node_q;
   logic [STW-1:0]      stack_q;

   // Request copy.
   logic [BLOCK_W-1:0]  blk_ff;
   logic [TARGET_W-1:0] tgt_ff;
   logic [COUNT_W-1:0]  bcnt_ff;

   // Walk state; the top stack frame lives in registers.
   logic [BW-1:0]       sweep_ff, sweep_in;
   logic [DW-1:0]       root_ff, root_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [BW-1:0]       top_node_ff, top_node_in;
   logic [CW-1:0]       top_slot_ff, top_slot_in;
   logic [CW-1:0]       top_cnt_ff, top_cnt_in;
   logic [MAX_SUCC-1:0] top_marks_ff, top_marks_in;

   // Query and result registers.
   logic [CW-1:0]       qslot_ff, qslot_in;
   logic                hit_any_ff, hit_any_in;
   logic                hit_back_ff, hit_back_in;
   logic                pend_pred_ff, pend_pred_in;
   logic                pend_stat_ff, pend_stat_in;
   logic                rsp_pred_ff, rsp_stat_ff;

   logic [BW-1:0]       blk_idx, t_idx;
   logic [MAX_SUCC-1:0] nd_marks;
   logic [1:0]          nd_color;
   logic [DW-1:0]       depth_m1, depth_m2;
   logic [SLW-1:0]      mark_idx;
   logic [AW-1:0]       walk_addr, q_addr, add_addr;

   logic                node_we, node_re, cnt_we, cnt_re, succ_re;
   logic [BW-1:0]       node_waddr, node_raddr, cnt_waddr, cnt_raddr;
   logic [NW-1:0]       node_wdata;
   logic [CW-1:0]       cnt_wdata;
   logic [AW-1:0]       succ_raddr;

   assign blk_idx   = BW'(blk_ff);
   assign t_idx     = BW'(succ_q);
   assign nd_marks  = node_q[MAX_SUCC-1:0];
   assign nd_color  = node_q[NW-1 -: 2];
   assign depth_m1  = depth_ff - DW'(1);
   assign depth_m2  = depth_ff - DW'(2);
   assign mark_idx  = SLW'(top_slot_ff - CW'(1));
   assign walk_addr = AW'(32'(top_node_ff) * MAX_SUCC + 32'(top_slot_ff));
   assign q_addr    = AW'(32'(blk_idx) * MAX_SUCC + 32'(qslot_ff));
   assign add_addr  = AW'(32'(blk_idx) * MAX_SUCC + 32'(cnt_q));

   // Port selection of the node and count memories.
   always_comb begin
      node_we    = cmd.sweep_wr | cmd.root_push | cmd.pop_top | cmd.tgt_push;
      node_waddr = sweep_ff;
      node_wdata = '0;
      if (cmd.root_push) begin
         node_waddr = root_ff[BW-1:0];
         node_wdata = {COLOR_GRAY, {MAX_SUCC{1'b0}}};
      end else if (cmd.pop_top) begin
         node_waddr = top_node_ff;
         node_wdata = {COLOR_BLACK, top_marks_ff};
      end else if (cmd.tgt_push) begin
         node_waddr = t_idx;
         node_wdata = {COLOR_GRAY, {MAX_SUCC{1'b0}}};
      end

      node_re    = cmd.rd_cnt_req | cmd.rd_root | cmd.rd_tgt;
      node_raddr = blk_idx;
      if (cmd.rd_root) node_raddr = root_ff[BW-1:0];
      else if (cmd.rd_tgt) node_raddr = t_idx;
      cnt_re    = node_re;
      cnt_raddr = node_raddr;

      cnt_we    = (cmd.sweep_wr & cmd.sweep_cnt) | cmd.add_wr;
      cnt_waddr = cmd.add_wr ? blk_idx : sweep_ff;
      cnt_wdata = cmd.add_wr ? cnt_q + CW'(1) : '0;

      succ_re    = cmd.rd_succ | cmd.q_rd;
      succ_raddr = cmd.q_rd ? q_addr : walk_addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.add_wr) succ_mem[add_addr] <= tgt_ff;
      if (succ_re) succ_q <= succ_mem[succ_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      if (cnt_re) cnt_q <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      if (node_re) node_q <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.tgt_push)
         stack_mem[depth_m1[BW-1:0]] <= {top_node_ff, top_slot_ff, top_cnt_ff, top_marks_ff};
      if (cmd.pop_top) stack_q <= stack_mem[depth_m2[BW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         blk_ff  <= req_block;
         tgt_ff  <= req_target;
         bcnt_ff <= req_block_count;
      end
   end

   // Walk register updates.
   always_comb begin
      sweep_in     = sweep_ff;
      root_in      = root_ff;
      depth_in     = depth_ff;
      top_node_in  = top_node_ff;
      top_slot_in  = top_slot_ff;
      top_cnt_in   = top_cnt_ff;
      top_marks_in = top_marks_ff;
      if (cmd.sweep_wr) sweep_in = st.sweep_last ? '0 : sweep_ff + BW'(1);
      if (cmd.walk_init) begin
         root_in  = '0;
         depth_in = '0;
      end
      if (cmd.root_skip) root_in = root_ff + DW'(1);
      if (cmd.root_push) begin
         root_in      = root_ff + DW'(1);
         depth_in     = DW'(1);
         top_node_in  = root_ff[BW-1:0];
         top_slot_in  = '0;
         top_cnt_in   = cnt_q;
         top_marks_in = '0;
      end
      if (cmd.rd_tgt) top_slot_in = top_slot_ff + CW'(1);
      if (cmd.tgt_push) begin
         depth_in     = depth_ff + DW'(1);
         top_node_in  = t_idx;
         top_slot_in  = '0;
         top_cnt_in   = cnt_q;
         top_marks_in = '0;
      end
      if (cmd.tgt_mark) top_marks_in[mark_idx] = 1'b1;
      if (cmd.pop_top) depth_in = depth_m1;
      if (cmd.stack_load) begin
         {top_node_in, top_slot_in, top_cnt_in, top_marks_in} = stack_q;
      end
   end

   // Query and result register updates.
   always_comb begin
      qslot_in     = qslot_ff;
      hit_any_in   = hit_any_ff;
      hit_back_in  = hit_back_ff;
      pend_pred_in = pend_pred_ff;
      pend_stat_in = pend_stat_ff;
      if (cmd.load_req) begin
         pend_pred_in = 1'b0;
         pend_stat_in = 1'b0;
      end
      if (cmd.res_reject) pend_stat_in = 1'b1;
      if (cmd.q_init) begin
         qslot_in    = '0;
         hit_any_in  = 1'b0;
         hit_back_in = 1'b0;
      end
      if (cmd.q_cmp) begin
         if (succ_q == tgt_ff) begin
            hit_any_in = 1'b1;
            if (nd_marks[SLW'(qslot_ff)]) hit_back_in = 1'b1;
         end
         qslot_in = qslot_ff + CW'(1);
      end
      // A block with any back edge predicts only its back edges.
      if (cmd.q_finish) pend_pred_in = (|nd_marks) ? hit_back_ff : hit_any_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff      <= root_in;
      depth_ff     <= depth_in;
      top_node_ff  <= top_node_in;
      top_slot_ff  <= top_slot_in;
      top_cnt_ff   <= top_cnt_in;
      top_marks_ff <= top_marks_in;
      qslot_ff     <= qslot_in;
      hit_any_ff   <= hit_any_in;
      hit_back_ff  <= hit_back_in;
      pend_pred_ff <= pend_pred_in;
      pend_stat_ff <= pend_stat_in;
      if (cmd.rsp_load) begin
         rsp_pred_ff <= pend_pred_ff;
         rsp_stat_ff <= pend_stat_ff;
      end
   end

   always_comb begin
      st.range_bad    = (32'(blk_ff) >= MAX_BLOCKS) || (32'(tgt_ff) >= MAX_BLOCKS);
      st.count_bad    = 32'(bcnt_ff) > MAX_BLOCKS;
      st.cnt_full     = 32'(cnt_q) >= MAX_SUCC;
      st.sweep_last   = sweep_ff == BW'(MAX_BLOCKS - 1);
      st.root_done    = root_ff == DW'(bcnt_ff);
      st.nd_white     = nd_color == COLOR_WHITE;
      st.nd_gray      = nd_color == COLOR_GRAY;
      st.top_has_slot = top_slot_ff < top_cnt_ff;
      st.depth_one    = depth_ff == DW'(1);
      st.q_more       = qslot_ff < cnt_q;
   end

   assign rsp_predicted = rsp_pred_ff;
   assign rsp_status    = rsp_stat_ff;

endmodule

/* rtl/back_edge_branch_predictor.sv */
`timescale 1ns / 1ps
// Back-edge static branch predictor. Edges are loaded per source block (up to
// MAX_SUCC each), a run request walks blocks 0..block_count-1 depth first and
// marks edges into gray blocks as back edges, and a query answers whether an
// edge is predicted taken. Every request gives one response. After reset the
// block sweeps its node and count memories before taking requests; a clear
// request sweeps them again. A response may wait in its output register while
// the next request is taken.
module back_edge_branch_predictor #(
   parameter int MAX_BLOCKS = bebp_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_SUCC   = bebp_pkg::MAX_SUCC_DEF
) (
   input logic        clock,
   input logic        reset,
   bebp_req_if.sink   req_ch,
   bebp_rsp_if.source rsp_ch
);
   import bebp_pkg::*;

   bebp_cmd_type  cmd;
   bebp_stat_type st;

   bebp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (bebp_action_type'(req_ch.action)),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .st         (st),
      .cmd        (cmd)
   );

   bebp_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .MAX_SUCC   (MAX_SUCC)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_block       (req_ch.block),
      .req_target      (req_ch.target),
      .req_block_count (req_ch.block_count),
      .cmd             (cmd),
      .st              (st),
      .rsp_predicted   (rsp_ch.predicted),
      .rsp_status      (rsp_ch.status)
   );

endmodule

/* rtl/bebp_check.sv */
`timescale 1ns / 1ps
// Port-level checks of the predictor, bound to the top level.
// Depends only on the top level's channel signals.
module bebp_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_predicted,
   input logic rsp_status
);
   // Requests accepted whose response has not yet been taken.
   logic [1:0] open_ff, open_in;

   always_comb begin
      open_in = open_ff;
      if (req_valid && req_ready) open_in = open_in + 2'd1;
      if (rsp_valid && rsp_ready) open_in = open_in - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) open_ff <= '0;
      else open_ff <= open_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_predicted) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   a_reject_no_pred: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_predicted)
      else $error("rejected request reported a prediction");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without a request");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two requests outstanding");

endmodule

bind back_edge_branch_predictor bebp_check u_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_predicted (rsp_ch.predicted),
   .rsp_status    (rsp_ch.status)
);
